### hw/rtl/ptc_pkg.sv
// shared types, constants and register map of the temperature converter
package ptc_pkg;

    localparam int CODE_W         = 12;
    localparam int INT_W          = 8;
    localparam int DEC_W          = 10;
    localparam int TEMP_W         = 24;
    localparam int QUO_W          = TEMP_W;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 5;
    localparam int ADC_BITS_DEF   = 12;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [INT_W-1:0]  RST_ROOM_INT = 8'd25;
    localparam logic [INT_W-1:0]  RST_HOT_INT  = 8'd85;
    localparam logic [DEC_W-1:0]  RST_DEC      = '0;
    localparam logic [CODE_W-1:0] RST_CODE     = '0;

    typedef enum logic [2:0] {
        REG_ROOM_TEMP_INT  = 3'd0,
        REG_ROOM_TEMP_DEC  = 3'd1,
        REG_HOT_TEMP_INT   = 3'd2,
        REG_HOT_TEMP_DEC   = 3'd3,
        REG_ROOM_PTAT_CODE = 3'd4,
        REG_HOT_PTAT_CODE  = 3'd5,
        REG_ROOM_CTAT_CODE = 3'd6,
        REG_HOT_CTAT_CODE  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_10   = 2'd0,
        DIV_100  = 2'd1,
        DIV_1000 = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic [INT_W-1:0]  room_temp_int;
        logic [DEC_W-1:0]  room_temp_dec;
        logic [INT_W-1:0]  hot_temp_int;
        logic [DEC_W-1:0]  hot_temp_dec;
        logic [CODE_W-1:0] room_ptat_code;
        logic [CODE_W-1:0] hot_ptat_code;
        logic [CODE_W-1:0] room_ctat_code;
        logic [CODE_W-1:0] hot_ctat_code;
    } t_cal;

    typedef struct packed {
        logic valid;
        logic neg;
        logic zd;
    } t_ctl;

endpackage

### hw/rtl/ptc_regs.sv
// apb calibration register file
module ptc_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ptc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ptc_pkg::APB_DATA_W-1:0]     prdata,
    output ptc_pkg::t_cal                      o_cal
);

    ptc_pkg::t_cal     r_cal;
    ptc_pkg::t_reg_idx n_idx;
    logic              n_wr;

    assign n_idx = ptc_pkg::t_reg_idx'(paddr[ptc_pkg::APB_ADDR_W-1:2]);
    assign n_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.room_temp_int  <= ptc_pkg::RST_ROOM_INT;
            r_cal.room_temp_dec  <= ptc_pkg::RST_DEC;
            r_cal.hot_temp_int   <= ptc_pkg::RST_HOT_INT;
            r_cal.hot_temp_dec   <= ptc_pkg::RST_DEC;
            r_cal.room_ptat_code <= ptc_pkg::RST_CODE;
            r_cal.hot_ptat_code  <= ptc_pkg::RST_CODE;
            r_cal.room_ctat_code <= ptc_pkg::RST_CODE;
            r_cal.hot_ctat_code  <= ptc_pkg::RST_CODE;
        end else if (n_wr) begin
            unique case (n_idx)
                ptc_pkg::REG_ROOM_TEMP_INT:
                    r_cal.room_temp_int  <= pwdata[ptc_pkg::INT_W-1:0];
                ptc_pkg::REG_ROOM_TEMP_DEC:
                    r_cal.room_temp_dec  <= pwdata[ptc_pkg::DEC_W-1:0];
                ptc_pkg::REG_HOT_TEMP_INT:
                    r_cal.hot_temp_int   <= pwdata[ptc_pkg::INT_W-1:0];
                ptc_pkg::REG_HOT_TEMP_DEC:
                    r_cal.hot_temp_dec   <= pwdata[ptc_pkg::DEC_W-1:0];
                ptc_pkg::REG_ROOM_PTAT_CODE:
                    r_cal.room_ptat_code <= pwdata[ptc_pkg::CODE_W-1:0];
                ptc_pkg::REG_HOT_PTAT_CODE:
                    r_cal.hot_ptat_code  <= pwdata[ptc_pkg::CODE_W-1:0];
                ptc_pkg::REG_ROOM_CTAT_CODE:
                    r_cal.room_ctat_code <= pwdata[ptc_pkg::CODE_W-1:0];
                ptc_pkg::REG_HOT_CTAT_CODE:
                    r_cal.hot_ctat_code  <= pwdata[ptc_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (n_idx)
            ptc_pkg::REG_ROOM_TEMP_INT:  prdata = ptc_pkg::APB_DATA_W'(r_cal.room_temp_int);
            ptc_pkg::REG_ROOM_TEMP_DEC:  prdata = ptc_pkg::APB_DATA_W'(r_cal.room_temp_dec);
            ptc_pkg::REG_HOT_TEMP_INT:   prdata = ptc_pkg::APB_DATA_W'(r_cal.hot_temp_int);
            ptc_pkg::REG_HOT_TEMP_DEC:   prdata = ptc_pkg::APB_DATA_W'(r_cal.hot_temp_dec);
            ptc_pkg::REG_ROOM_PTAT_CODE: prdata = ptc_pkg::APB_DATA_W'(r_cal.room_ptat_code);
            ptc_pkg::REG_HOT_PTAT_CODE:  prdata = ptc_pkg::APB_DATA_W'(r_cal.hot_ptat_code);
            ptc_pkg::REG_ROOM_CTAT_CODE: prdata = ptc_pkg::APB_DATA_W'(r_cal.room_ctat_code);
            ptc_pkg::REG_HOT_CTAT_CODE:  prdata = ptc_pkg::APB_DATA_W'(r_cal.hot_ctat_code);
            default:                     prdata = '0;
        endcase
    end

    assign o_cal = r_cal;

endmodule

### hw/rtl/ptc_frac.sv
// calibration temperature rebuild: integer part plus scaled decimal part
module ptc_frac #(
    parameter int               FRAC_BITS = ptc_pkg::FRAC_BITS_DEF,
    parameter logic [7:0]       RST_INT   = ptc_pkg::RST_ROOM_INT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ptc_pkg::INT_W-1:0]     i_int,
    input  logic [ptc_pkg::DEC_W-1:0]     i_dec,
    output logic [FRAC_BITS+8:0]          o_tl
);

    localparam int XW  = FRAC_BITS + 11;
    localparam int MW  = XW - 3;
    localparam int PW  = XW + MW;
    localparam int FW  = FRAC_BITS + 1;
    localparam int TLW = FRAC_BITS + 9;
    localparam logic [63:0] ONE64 = 64'd1;
    localparam logic [63:0] M10_F   = (ONE64 << XW) / 10;
    localparam logic [63:0] M100_F  = (ONE64 << XW) / 100;
    localparam logic [63:0] M1000_F = (ONE64 << XW) / 1000;

    ptc_pkg::t_div_sel n_sel, r_sel;
    logic [MW-1:0]     n_m;
    logic [XW-1:0]     n_half, n_x, r_x;
    logic [PW-1:0]     n_p, r_p;
    logic [MW-1:0]     n_q0;
    logic [XW-1:0]     n_dv, n_r;
    logic              n_corr;
    logic [FW-1:0]     n_frac;
    logic [TLW-1:0]    n_tl, r_tl;

    // reciprocal estimate, low by at most one
    always_comb begin
        priority if (i_dec < ptc_pkg::DEC_W'(10)) begin
            n_sel  = ptc_pkg::DIV_10;
        end else if (i_dec < ptc_pkg::DEC_W'(100)) begin
            n_sel  = ptc_pkg::DIV_100;
        end else begin
            n_sel  = ptc_pkg::DIV_1000;
        end
        unique case (n_sel)
            ptc_pkg::DIV_10:   begin n_m = M10_F[MW-1:0];   n_half = XW'(5);   end
            ptc_pkg::DIV_100:  begin n_m = M100_F[MW-1:0];  n_half = XW'(50);  end
            ptc_pkg::DIV_1000: begin n_m = M1000_F[MW-1:0]; n_half = XW'(500); end
            default:           begin n_m = M1000_F[MW-1:0]; n_half = XW'(500); end
        endcase
        n_x = (XW'(i_dec) << FRAC_BITS) + n_half;
        n_p = PW'(n_x) * PW'(n_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p   <= '0;
            r_x   <= '0;
            r_sel <= ptc_pkg::DIV_10;
        end else begin
            r_p   <= n_p;
            r_x   <= n_x;
            r_sel <= n_sel;
        end
    end

    always_comb begin
        unique case (r_sel)
            ptc_pkg::DIV_10:   n_dv = XW'(10);
            ptc_pkg::DIV_100:  n_dv = XW'(100);
            ptc_pkg::DIV_1000: n_dv = XW'(1000);
            default:           n_dv = XW'(1000);
        endcase
        n_q0   = r_p[PW-1:XW];
        n_r    = r_x - XW'(n_q0) * n_dv;
        n_corr = (n_r >= n_dv);
        n_frac = FW'(n_q0) + FW'(n_corr);
        n_tl   = (TLW'(i_int) << FRAC_BITS) + TLW'(n_frac);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl <= TLW'(RST_INT) << FRAC_BITS;
        end else begin
            r_tl <= n_tl;
        end
    end

    assign o_tl = r_tl;

endmodule

### hw/rtl/ptc_front.sv
// front pipeline: products, two-point numerator and denominator magnitudes
module ptc_front #(
    parameter int ADC_BITS  = ptc_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = ptc_pkg::FRAC_BITS_DEF,
    parameter int AW  = (ADC_BITS < ptc_pkg::CODE_W) ? ADC_BITS : ptc_pkg::CODE_W,
    parameter int NW  = FRAC_BITS + 2 * AW + 11,
    parameter int DMW = 2 * AW + 1 + FRAC_BITS - 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ptc_pkg::CODE_W-1:0]    i_ptat,
    input  logic [ptc_pkg::CODE_W-1:0]    i_ctat,
    input  ptc_pkg::t_cal                 i_cal,
    input  logic [FRAC_BITS+8:0]          i_room_tl,
    input  logic [FRAC_BITS+8:0]          i_hot_tl,
    output ptc_pkg::t_ctl                 o_ctl,
    output logic [NW-1:0]                 o_nmag,
    output logic [DMW-1:0]                o_dmag
);

    localparam int PW  = 2 * AW;
    localparam int SW  = 2 * AW + 1;
    localparam int DW  = 2 * AW + 2;
    localparam int TLW = FRAC_BITS + 9;

    logic [AW-1:0]        n_tp, n_tc, n_vpl, n_vph, n_vcl, n_vch;
    logic [PW-1:0]        n_p1, n_p2, n_p3, n_p4;
    logic [PW-1:0]        r_p1, r_p2, r_p3, r_p4;
    logic                 r_v1, r_v2, r_v3;
    logic signed [SW-1:0] n_a, n_b, r_a, r_b;
    logic signed [DW-1:0] n_den, r_den2, r_den3;
    logic signed [NW-1:0] n_m1, n_m2, r_m1, r_m2, n_num;
    logic [DW-1:0]        n_dabs;
    ptc_pkg::t_ctl        n_ctl, r_ctl;
    logic [NW-1:0]        n_nmag, r_nmag;
    logic [DMW-1:0]       n_dmag, r_dmag;

    // stage 1: code products
    always_comb begin
        n_tp  = i_ptat[AW-1:0];
        n_tc  = i_ctat[AW-1:0];
        n_vpl = i_cal.room_ptat_code[AW-1:0];
        n_vph = i_cal.hot_ptat_code[AW-1:0];
        n_vcl = i_cal.room_ctat_code[AW-1:0];
        n_vch = i_cal.hot_ctat_code[AW-1:0];
        n_p1  = PW'(n_vph) * PW'(n_tc);
        n_p2  = PW'(n_vch) * PW'(n_tp);
        n_p3  = PW'(n_vcl) * PW'(n_tp);
        n_p4  = PW'(n_vpl) * PW'(n_tc);
    end

    // stage 2: den = p3 - p2 + p1 - p4 reuses the same products
    always_comb begin
        n_a   = $signed(SW'(r_p1) - SW'(r_p2));
        n_b   = $signed(SW'(r_p3) - SW'(r_p4));
        n_den = $signed(DW'(r_p3) + DW'(r_p1) - DW'(r_p2) - DW'(r_p4));
    end

    // stage 3: weight by calibration temperatures
    always_comb begin
        n_m1 = NW'($signed({1'b0, i_room_tl})) * NW'(r_a);
        n_m2 = NW'($signed({1'b0, i_hot_tl})) * NW'(r_b);
    end

    // stage 4: sign and magnitude split
    always_comb begin
        n_num       = r_m1 + r_m2;
        n_nmag      = n_num[NW-1] ? (~n_num + NW'(1)) : n_num;
        n_dabs      = r_den3[DW-1] ? (~r_den3 + DW'(1)) : r_den3;
        n_dmag      = DMW'(n_dabs[DW-2:0]) << (FRAC_BITS - 8);
        n_ctl.valid = r_v3;
        n_ctl.neg   = n_num[NW-1] ^ r_den3[DW-1];
        n_ctl.zd    = (r_den3 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_ctl <= '0;
        end else begin
            r_v1  <= i_valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_p3   <= n_p3;
        r_p4   <= n_p4;
        r_a    <= n_a;
        r_b    <= n_b;
        r_den2 <= n_den;
        r_m1   <= n_m1;
        r_m2   <= n_m2;
        r_den3 <= r_den2;
        r_nmag <= n_nmag;
        r_dmag <= n_dmag;
    end

    assign o_ctl  = r_ctl;
    assign o_nmag = r_nmag;
    assign o_dmag = r_dmag;

endmodule

### hw/rtl/ptc_div.sv
// pipelined restoring divider, one quotient bit per stage, then round and clip
module ptc_div #(
    parameter int NW  = 51,
    parameter int DMW = 33
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ptc_pkg::t_ctl                     i_ctl,
    input  logic [NW-1:0]                     i_nmag,
    input  logic [DMW-1:0]                    i_dmag,
    output logic                              o_valid,
    output logic signed [ptc_pkg::TEMP_W-1:0] o_temperature,
    output logic                              o_zero_denominator,
    output logic                              o_saturated
);

    localparam int QB = ptc_pkg::QUO_W;
    localparam int CW = (NW > DMW + QB) ? NW : DMW + QB;
    localparam logic [QB:0] LIM_POS = (QB+1)'((1 << (QB - 1)) - 1);
    localparam logic [QB:0] LIM_NEG = (QB+1)'(1 << (QB - 1));
    localparam logic [QB-1:0] T_MAX = LIM_POS[QB-1:0];
    localparam logic [QB-1:0] T_MIN = LIM_NEG[QB-1:0];

    ptc_pkg::t_ctl  r_ctl [0:QB];
    logic [CW-1:0]  r_rem [0:QB];
    logic [QB-1:0]  r_q   [0:QB];
    logic [DMW-1:0] r_dm  [0:QB];
    logic           r_ovf [0:QB];

    logic           n_ovf;
    logic [QB:0]    n_qr, n_lim, n_mag;
    logic           n_rnd, n_sat;
    logic [QB-1:0]  n_temp;
    logic           r_valid, r_zd, r_sat;
    logic [QB-1:0]  r_temp;

    // a quotient wider than QB bits always clips, unless the denominator is zero
    assign n_ovf = (CW'(i_nmag) >= (CW'(i_dmag) << QB));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= CW'(i_nmag);
        r_q[0]   <= '0;
        r_dm[0]  <= i_dmag;
        r_ovf[0] <= n_ovf;
    end

    for (genvar gi = 0; gi < QB; gi++) begin : g_stage
        localparam int K = QB - 1 - gi;
        logic [CW-1:0] n_dk, n_rem;
        logic          n_ge;

        always_comb begin
            n_dk  = CW'(r_dm[gi]) << K;
            n_ge  = (r_rem[gi] >= n_dk);
            n_rem = n_ge ? (r_rem[gi] - n_dk) : r_rem[gi];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[gi+1] <= '0;
            end else begin
                r_ctl[gi+1] <= r_ctl[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[gi+1] <= n_rem;
            r_q[gi+1]   <= {r_q[gi][QB-2:0], n_ge};
            r_dm[gi+1]  <= r_dm[gi];
            r_ovf[gi+1] <= r_ovf[gi];
        end
    end

    // round half away from zero on the magnitude, then clip by sign; a zero denominator gives zero
    always_comb begin
        n_rnd = ({r_rem[QB], 1'b0} >= (CW+1)'(r_dm[QB]));
        n_qr  = (QB+1)'(r_q[QB]) + (QB+1)'(n_rnd);
        n_lim = r_ctl[QB].neg ? LIM_NEG : LIM_POS;
        n_sat = r_ovf[QB] || (n_qr > n_lim);
        n_mag = n_sat ? n_lim : n_qr;
        n_temp = r_ctl[QB].neg ? QB'((~n_mag) + (QB+1)'(1)) : n_mag[QB-1:0];
        if (r_ctl[QB].zd) begin
            n_sat  = 1'b0;
            n_temp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl[QB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp <= n_temp;
        r_zd   <= r_ctl[QB].zd;
        r_sat  <= n_sat;
    end

    assign o_valid            = r_valid;
    assign o_temperature      = $signed(r_temp);
    assign o_zero_denominator = r_zd;
    assign o_saturated        = r_sat;

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[QB].valid && !r_ovf[QB] |-> r_rem[QB] < CW'(r_dm[QB]))
        else $error("remainder not below divisor at last stage");

    a_zero_den_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_zd |-> !r_sat && r_temp == '0)
        else $error("zero denominator result not cleared");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_sat |-> r_temp == T_MAX || r_temp == T_MIN)
        else $error("clipped result not at range limit");

endmodule

### hw/rtl/ptat_ctat_temperature_convert_top.sv
// top level of the ptat/ctat two-point temperature converter
//
// A command is a transfer of one ptat/ctat reading pair: it is taken at a rising
// edge with start high and busy low. busy is always low, so a new pair may be
// sent every cycle. Each pair yields one result, shown on o_temperature,
// o_zero_denominator and o_saturated for exactly one cycle while o_valid is high;
// the receiver cannot stall, and results leave in the order pairs came in.
// A result passes four front stages for products, calibration weighting and sign
// split, one range check stage, one stage per quotient bit of the divider, and a
// round/clip output stage. Throughput is one pair per cycle, set by the fully
// pipelined divider. Calibration registers sit on the apb port at byte address
// 4*index; the user must write them only with no pair in flight, as the block
// does not enforce it. A rebuilt calibration temperature follows its register
// write through the product and result registers of ptc_frac.
// A synchronous reset loads the calibration defaults (25 and 85 degrees, zero
// codes) and drops every pair in flight; no result appears from before reset.
module ptat_ctat_temperature_convert_top #(
    parameter int ADC_BITS  = ptc_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = ptc_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ptc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ptc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [ptc_pkg::CODE_W-1:0]        i_ptat_reading,
    input  logic [ptc_pkg::CODE_W-1:0]        i_ctat_reading,
    output logic                              o_valid,
    output logic signed [ptc_pkg::TEMP_W-1:0] o_temperature,
    output logic                              o_zero_denominator,
    output logic                              o_saturated
);

    localparam int AW  = (ADC_BITS < ptc_pkg::CODE_W) ? ADC_BITS : ptc_pkg::CODE_W;
    localparam int NW  = FRAC_BITS + 2 * AW + 11;
    localparam int DMW = 2 * AW + 1 + FRAC_BITS - 8;
    localparam int LAT = ptc_pkg::QUO_W + 6;

    ptc_pkg::t_cal         w_cal;
    ptc_pkg::t_ctl         w_ctl;
    logic [FRAC_BITS+8:0]  w_room_tl, w_hot_tl;
    logic [NW-1:0]         w_nmag;
    logic [DMW-1:0]        w_dmag;
    logic                  w_accept;

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    ptc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cal   (w_cal)
    );

    ptc_frac #(
        .FRAC_BITS (FRAC_BITS),
        .RST_INT   (ptc_pkg::RST_ROOM_INT)
    ) u_frac_room (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_int   (w_cal.room_temp_int),
        .i_dec   (w_cal.room_temp_dec),
        .o_tl    (w_room_tl)
    );

    ptc_frac #(
        .FRAC_BITS (FRAC_BITS),
        .RST_INT   (ptc_pkg::RST_HOT_INT)
    ) u_frac_hot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_int   (w_cal.hot_temp_int),
        .i_dec   (w_cal.hot_temp_dec),
        .o_tl    (w_hot_tl)
    );

    ptc_front #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW),
        .NW        (NW),
        .DMW       (DMW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_ptat    (i_ptat_reading),
        .i_ctat    (i_ctat_reading),
        .i_cal     (w_cal),
        .i_room_tl (w_room_tl),
        .i_hot_tl  (w_hot_tl),
        .o_ctl     (w_ctl),
        .o_nmag    (w_nmag),
        .o_dmag    (w_dmag)
    );

    ptc_div #(
        .NW  (NW),
        .DMW (DMW)
    ) u_div (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .i_nmag             (w_nmag),
        .i_dmag             (w_dmag),
        .o_valid            (o_valid),
        .o_temperature      (o_temperature),
        .o_zero_denominator (o_zero_denominator),
        .o_saturated        (o_saturated)
    );

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LAT))
        else $error("result without a matching command transfer");

endmodule

### bench/ptat_ctat_temperature_convert_top_tb.sv
// self-checking testbench of the two-point ptat/ctat temperature converter
`timescale 1ns / 100ps

module ptat_ctat_temperature_convert_top_tb;
    import ptc_pkg::*;

    localparam int RAND_PER_PHASE = 48;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int N_RESET_ROWS   = 4;
    localparam int N_ROWS         = 20;
    localparam int N_PHASES       = 11;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     zd;
        logic                     sat;
    } temp_result_t;

    typedef struct {
        logic [CODE_W-1:0] ptat;
        logic [CODE_W-1:0] ctat;
        bit                typed;
        temp_result_t      res;
    } stim_row_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     start;
    logic                     busy;
    logic [CODE_W-1:0]        i_ptat_reading;
    logic [CODE_W-1:0]        i_ctat_reading;
    logic                     o_valid;
    logic signed [TEMP_W-1:0] o_temperature;
    logic                     o_zero_denominator;
    logic                     o_saturated;

    temp_result_t expected_temps[$];
    t_cal         cal_shadow;
    int           fail_count;
    int           cycle_count;
    stim_row_t    rows[N_ROWS];
    t_cal         phase_cal[N_PHASES];

    ptat_ctat_temperature_convert_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .start              (start),
        .busy               (busy),
        .i_ptat_reading     (i_ptat_reading),
        .i_ctat_reading     (i_ctat_reading),
        .o_valid            (o_valid),
        .o_temperature      (o_temperature),
        .o_zero_denominator (o_zero_denominator),
        .o_saturated        (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // decimal digits to 16 fraction bits, rounded half up
    function automatic longint dec_frac(input logic [DEC_W-1:0] d);
        longint dv;
        begin
            dv = (d < 10) ? 10 : ((d < 100) ? 100 : 1000);
            return ((longint'(d) <<< 16) + dv / 2) / dv;
        end
    endfunction

    function automatic temp_result_t convert_temp(input logic [CODE_W-1:0] tp_r,
                                                  input logic [CODE_W-1:0] tc_r,
                                                  input t_cal c);
        longint       tp, tc, vpl, vph, vcl, vch, tl, th, a, b, den, num, dv, quo, rm, lim, t;
        bit           nneg, rneg, sat;
        temp_result_t r;
        begin
            tp  = longint'(tp_r);
            tc  = longint'(tc_r);
            vpl = longint'(c.room_ptat_code);
            vph = longint'(c.hot_ptat_code);
            vcl = longint'(c.room_ctat_code);
            vch = longint'(c.hot_ctat_code);
            tl  = (longint'(c.room_temp_int) <<< 16) + dec_frac(c.room_temp_dec);
            th  = (longint'(c.hot_temp_int) <<< 16) + dec_frac(c.hot_temp_dec);
            a   = vph * tc - vch * tp;
            b   = vcl * tp - vpl * tc;
            den = tp * (vcl - vch) + tc * (vph - vpl);
            r   = '0;
            if (den == 0) begin
                r.zd = 1'b1;
                return r;
            end
            num  = tl * a + th * b;
            nneg = num < 0;
            if (nneg) num = -num;
            dv   = ((den < 0) ? -den : den) <<< 8;
            quo  = num / dv;
            rm   = num % dv;
            rneg = nneg != (den < 0);
            lim  = rneg ? 64'sd8388608 : 64'sd8388607;
            sat  = 1'b0;
            if (quo > (64'sd1 <<< 32)) begin
                sat = 1'b1;
            end else if (2 * rm >= dv) begin
                quo = quo + 1;
            end
            if (sat || quo > lim) begin
                quo = lim;
                sat = 1'b1;
            end
            t     = rneg ? -quo : quo;
            r.temp = t[TEMP_W-1:0];
            r.sat  = sat;
            return r;
        end
    endfunction

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        begin
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            penable <= 1'b0;
            paddr   <= APB_ADDR_W'(idx) << 2;
            pwdata  <= val;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic load_cal(input t_cal c);
        begin
            apb_write(REG_ROOM_TEMP_INT, APB_DATA_W'(c.room_temp_int));
            apb_write(REG_ROOM_TEMP_DEC, APB_DATA_W'(c.room_temp_dec));
            apb_write(REG_HOT_TEMP_INT, APB_DATA_W'(c.hot_temp_int));
            apb_write(REG_HOT_TEMP_DEC, APB_DATA_W'(c.hot_temp_dec));
            apb_write(REG_ROOM_PTAT_CODE, APB_DATA_W'(c.room_ptat_code));
            apb_write(REG_HOT_PTAT_CODE, APB_DATA_W'(c.hot_ptat_code));
            apb_write(REG_ROOM_CTAT_CODE, APB_DATA_W'(c.room_ctat_code));
            apb_write(REG_HOT_CTAT_CODE, APB_DATA_W'(c.hot_ctat_code));
            cal_shadow = c;
            // rebuilt calibration temperatures settle after the write
            repeat (4) @(posedge i_clk);
        end
    endtask

    // let the pipeline empty before touching calibration
    task automatic drain;
        begin
            start <= 1'b0;
            @(posedge i_clk);
            while (expected_temps.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
    endtask

    // start stays high across back-to-back transfers; gaps lower it
    task automatic send_pair(input logic [CODE_W-1:0] tp, input logic [CODE_W-1:0] tc,
                             input bit typed, input temp_result_t typed_res);
        begin
            start          <= 1'b1;
            i_ptat_reading <= tp;
            i_ctat_reading <= tc;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            expected_temps.push_back(typed ? typed_res : convert_temp(tp, tc, cal_shadow));
        end
    endtask

    task automatic maybe_gap(inout int burst_left);
        int gap;
        begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    function automatic logic [CODE_W-1:0] near_code(input logic [CODE_W-1:0] base);
        int v;
        begin
            v = int'(base) + $urandom_range(0, 16) - 8;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            return CODE_W'(v);
        end
    endfunction

    always @(posedge i_clk) begin
        temp_result_t exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_temps.size() == 0) begin
                $display("%0t: unexpected result temp=%0d zd=%0b sat=%0b", $time,
                         o_temperature, o_zero_denominator, o_saturated);
                fail_count++;
            end else begin
                exp_r = expected_temps.pop_front();
                if (o_temperature !== exp_r.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             exp_r.temp, o_temperature);
                    fail_count++;
                end
                if (o_zero_denominator !== exp_r.zd) begin
                    $display("%0t: zero_denominator expected %0b actual %0b", $time,
                             exp_r.zd, o_zero_denominator);
                    fail_count++;
                end
                if (o_saturated !== exp_r.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             exp_r.sat, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        temp_result_t zd_res;
        temp_result_t no_res;
        int           burst_left;
        t_cal         rc;
        logic [CODE_W-1:0] tp, tc;

        fail_count     = 0;
        cycle_count    = 0;
        burst_left     = 0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        start          = 1'b0;
        i_ptat_reading = '0;
        i_ctat_reading = '0;
        cal_shadow     = '{RST_ROOM_INT, RST_DEC, RST_HOT_INT, RST_DEC,
                           RST_CODE, RST_CODE, RST_CODE, RST_CODE};
        zd_res         = '{temp: '0, zd: 1'b1, sat: 1'b0};
        no_res         = '0;

        // reset calibration has all codes zero: every pair hits a zero denominator
        rows[0]  = '{12'd0,    12'd0,    1'b1, zd_res};
        rows[1]  = '{12'd4095, 12'd4095, 1'b1, zd_res};
        rows[2]  = '{12'd4095, 12'd0,    1'b1, zd_res};
        rows[3]  = '{12'd0,    12'd4095, 1'b1, zd_res};
        // typical calibration from here on
        rows[4]  = '{12'd0,    12'd0,    1'b1, zd_res};
        rows[5]  = '{12'd1000, 12'd3000, 1'b0, no_res};
        rows[6]  = '{12'd3000, 12'd1000, 1'b0, no_res};
        rows[7]  = '{12'd2000, 12'd2000, 1'b0, no_res};
        rows[8]  = '{12'd4095, 12'd4095, 1'b0, no_res};
        rows[9]  = '{12'd4095, 12'd0,    1'b0, no_res};
        rows[10] = '{12'd0,    12'd4095, 1'b0, no_res};
        rows[11] = '{12'd1,    12'd0,    1'b0, no_res};
        rows[12] = '{12'd0,    12'd1,    1'b0, no_res};
        rows[13] = '{12'd4094, 12'd1,    1'b0, no_res};
        rows[14] = '{12'd1,    12'd4094, 1'b0, no_res};
        rows[15] = '{12'd2048, 12'd2047, 1'b0, no_res};
        rows[16] = '{12'd1500, 12'd2500, 1'b0, no_res};
        rows[17] = '{12'd2500, 12'd1500, 1'b0, no_res};
        rows[18] = '{12'hAAA,  12'h555,  1'b0, no_res};
        rows[19] = '{12'h555,  12'hAAA,  1'b0, no_res};

        phase_cal[0]  = '{8'd25, 10'd0, 8'd85, 10'd0, 12'd1000, 12'd3000, 12'd3000, 12'd1000};
        phase_cal[1]  = '{8'd25, 10'd5, 8'd85, 10'd50, 12'd1200, 12'd2900, 12'd2800, 12'd900};
        phase_cal[2]  = '{8'd30, 10'd999, 8'd105, 10'd1023,
                          12'd1100, 12'd2100, 12'd3100, 12'd1600};
        phase_cal[3]  = '{8'd255, 10'd1023, 8'd255, 10'd1023,
                          12'd4095, 12'd4095, 12'd4095, 12'd4095};
        phase_cal[4]  = '{8'd0, 10'd0, 8'd0, 10'd0, 12'd0, 12'd4095, 12'd4095, 12'd0};
        // tiny denominator against a large weighted numerator: clips both ways
        phase_cal[5]  = '{8'd255, 10'd999, 8'd0, 10'd0, 12'd4094, 12'd4095, 12'd0, 12'd0};
        phase_cal[6]  = '{8'd0, 10'd0, 8'd255, 10'd999, 12'd4094, 12'd4095, 12'd0, 12'd0};
        phase_cal[7]  = '{8'd0, 10'd1, 8'd255, 10'd99, 12'd0, 12'd1, 12'd0, 12'd0};
        phase_cal[8]  = '{8'd85, 10'd0, 8'd25, 10'd0, 12'd3000, 12'd1000, 12'd1000, 12'd3000};
        phase_cal[9]  = '{8'd1, 10'd9, 8'd2, 10'd10, 12'd2047, 12'd2048, 12'd2048, 12'd2047};
        phase_cal[10] = '{8'd128, 10'd500, 8'd127, 10'd100,
                          12'd4095, 12'd0, 12'd0, 12'd4095};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            if (i == N_RESET_ROWS) begin
                drain();
                load_cal(phase_cal[0]);
            end
            send_pair(rows[i].ptat, rows[i].ctat, rows[i].typed, rows[i].res);
            maybe_gap(burst_left);
        end

        for (int p = 0; p < N_PHASES + 2; p++) begin
            drain();
            if (p < N_PHASES) begin
                rc = phase_cal[p];
            end else begin
                rc = '{INT_W'($urandom_range(0, 255)), DEC_W'($urandom_range(0, 1023)),
                       INT_W'($urandom_range(0, 255)), DEC_W'($urandom_range(0, 1023)),
                       CODE_W'($urandom_range(0, 4095)), CODE_W'($urandom_range(0, 4095)),
                       CODE_W'($urandom_range(0, 4095)), CODE_W'($urandom_range(0, 4095))};
            end
            load_cal(rc);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        tp = CODE_W'($urandom_range(0, 4095));
                        tc = CODE_W'($urandom_range(0, 4095));
                    end
                    1: begin
                        tp = near_code($urandom_range(0, 1) ? rc.room_ptat_code
                                                            : rc.hot_ptat_code);
                        tc = near_code($urandom_range(0, 1) ? rc.room_ctat_code
                                                            : rc.hot_ctat_code);
                    end
                    2: begin
                        tp = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
                        tc = $urandom_range(0, 1) ? near_code(12'd4095) : near_code(12'd0);
                    end
                    default: begin
                        tp = CODE_W'($urandom_range(0, 4095));
                        tc = near_code(tp);
                    end
                endcase
                send_pair(tp, tc, 1'b0, no_res);
                maybe_gap(burst_left);
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (expected_temps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_regs.sv
hw/rtl/ptc_frac.sv
hw/rtl/ptc_front.sv
hw/rtl/ptc_div.sv
hw/rtl/ptat_ctat_temperature_convert_top.sv
bench/ptat_ctat_temperature_convert_top_tb.sv
